@@ design/ucpq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the USB charge presence qualifier.
// No dependencies; used by ucpq_step and usb_charge_presence_qualifier.
package ucpq_pkg;

   localparam int unsigned COUNT_WIDTH     = 9;
   localparam int unsigned LIMIT_WIDTH     = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned REQ_DATA_WIDTH  = 8;
   localparam int unsigned RSP_DATA_WIDTH  = 8;

   localparam logic [LIMIT_WIDTH-1:0] ONLINE_SETTLE_RESET = 8'd30;
   localparam logic [LIMIT_WIDTH-1:0] ABSENT_SETTLE_RESET = 8'd1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONLINE_SETTLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ABSENT_SETTLE = 2'd1;

   localparam logic [1:0] LINK_ONLINE   = 2'd1;
   localparam logic [1:0] LINK_POWER_ON = 2'd2;

   typedef enum logic [2:0] {
      STATUS_NONE        = 3'd0,
      STATUS_OFFLINE     = 3'd1,
      STATUS_CHARGING    = 3'd2,
      STATUS_NOT_CHARGING = 3'd3,
      STATUS_NOT_STABLE  = 3'd4,
      STATUS_HOLD        = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      LAST_NONE         = 2'd0,
      LAST_CHARGING     = 2'd1,
      LAST_NOT_CHARGING = 2'd2,
      LAST_NOT_STABLE   = 2'd3
   } last_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] present_count;
      logic [COUNT_WIDTH-1:0] absent_online_count;
      logic [COUNT_WIDTH-1:0] absent_idle_count;
      logic                   charge_settled;
      last_type               last_reported;
   } qual_state_type;

endpackage

@@ design/ucpq_step.sv @@
`timescale 1ns / 1ps
// Next-state and status logic for one poll tick of the qualifier.
// Depends on ucpq_pkg.
module ucpq_step (
   input  ucpq_pkg::qual_state_type          cur,
   input  logic [1:0]                        link_state,
   input  logic                              supply_present,
   input  logic [ucpq_pkg::LIMIT_WIDTH-1:0]  online_limit,
   input  logic [ucpq_pkg::LIMIT_WIDTH-1:0]  absent_limit,
   output ucpq_pkg::qual_state_type          nxt,
   output ucpq_pkg::status_type              status
);

   logic [ucpq_pkg::COUNT_WIDTH-1:0] lim_on;
   logic [ucpq_pkg::COUNT_WIDTH-1:0] lim_off;

   assign lim_on  = {1'b0, online_limit};
   assign lim_off = {1'b0, absent_limit};

   always_comb begin
      logic [ucpq_pkg::COUNT_WIDTH-1:0] pc;
      logic [ucpq_pkg::COUNT_WIDTH-1:0] ac;
      ucpq_pkg::status_type             st;
      ucpq_pkg::last_type               code;
      logic                             reportable;

      nxt  = cur;
      st   = ucpq_pkg::STATUS_NONE;
      pc   = cur.present_count;
      ac   = '0;
      code = ucpq_pkg::LAST_NOT_STABLE;
      reportable = 1'b0;

      if (link_state inside {ucpq_pkg::LINK_ONLINE, ucpq_pkg::LINK_POWER_ON}) begin
         nxt.absent_idle_count = '0;
         // unplug flicker: drop a stale present count on an online link
         if (cur.last_reported == ucpq_pkg::LAST_CHARGING &&
             link_state == ucpq_pkg::LINK_ONLINE && !cur.charge_settled &&
             pc >= lim_on) begin
            pc = '0;
         end
         if (!supply_present) begin
            pc = '0;
            ac = cur.absent_online_count;
            if (ac < lim_off) begin
               ac = ac + 1'b1;
            end
            if (ac == lim_off) begin
               ac = ac + 1'b1;
               st = ucpq_pkg::STATUS_OFFLINE;
            end
            nxt.absent_online_count = ac;
         end else begin
            nxt.absent_online_count = '0;
            if (pc == '0) begin
               st = ucpq_pkg::STATUS_OFFLINE;
            end
            if (pc != '0 && pc < lim_on) begin
               pc = pc + 1'b1;
               st = ucpq_pkg::STATUS_NOT_STABLE;
            end
            if (pc == lim_on) begin
               pc = pc + 1'b1;
               nxt.charge_settled = 1'b1;
            end
         end
      end else begin
         nxt.absent_online_count = '0;
         if (supply_present) begin
            nxt.absent_idle_count = '0;
            if (pc < lim_on) begin
               pc = pc + 1'b1;
            end
            if (pc == lim_on) begin
               pc = pc + 1'b1;
               st = ucpq_pkg::STATUS_CHARGING;
            end
         end else begin
            pc = '0;
            ac = cur.absent_idle_count;
            if (ac < lim_off) begin
               ac = ac + 1'b1;
            end
            if (ac == lim_off) begin
               ac = ac + 1'b1;
               nxt.charge_settled = 1'b0;
               st = ucpq_pkg::STATUS_NOT_CHARGING;
            end
            nxt.absent_idle_count = ac;
         end
      end
      nxt.present_count = pc;

      if (nxt.charge_settled && cur.last_reported == ucpq_pkg::LAST_NOT_CHARGING) begin
         nxt.last_reported = ucpq_pkg::LAST_CHARGING;
      end

      case (st)
         ucpq_pkg::STATUS_CHARGING: begin
            code = ucpq_pkg::LAST_CHARGING;
            reportable = 1'b1;
         end
         ucpq_pkg::STATUS_NOT_CHARGING: begin
            code = ucpq_pkg::LAST_NOT_CHARGING;
            reportable = 1'b1;
         end
         ucpq_pkg::STATUS_NOT_STABLE: begin
            code = ucpq_pkg::LAST_NOT_STABLE;
            reportable = 1'b1;
         end
         default: begin
            code = ucpq_pkg::LAST_NOT_STABLE;
            reportable = 1'b0;
         end
      endcase

      if (reportable) begin
         if (nxt.last_reported == code) begin
            st = ucpq_pkg::STATUS_HOLD;
         end else begin
            nxt.last_reported = code;
         end
      end

      status = st;
   end

endmodule

@@ design/usb_charge_presence_qualifier.sv @@
`timescale 1ns / 1ps
// Top level of the USB charge presence qualifier: handshakes, settle
// registers and debounce state. Depends on ucpq_pkg and ucpq_step.
//
// One req item is one poll tick: link state and raw supply-present pin.
// Every item gives exactly one rsp item carrying the qualified status
// (none, offline, charging, not charging, not stable or hold).
// The status is in the rsp register at the edge after acceptance.
// Throughput is one item per cycle unless rsp stalls; the tick
// update is a single ucpq_step pass between the state registers.
// The csr channel writes the online and absent settle counts (index 0
// and 1); it is always ready and writes beyond the list are dropped.
// Settle counts should only change with no item in flight.
// Reset clears the debounce counters, the settled flag and the last
// report, loads settle counts of 30 and 1 and empties the rsp register.
// When the receiver stalls, the rsp register holds its item and req
// is taken only once that item leaves (in the same cycle is fine).
module usb_charge_presence_qualifier (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] link_state, [2] supply_present, rest zero
   input  logic [ucpq_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] status, rest zero
   output logic [ucpq_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ucpq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ucpq_pkg::LIMIT_WIDTH-1:0]      csr_data
);

   ucpq_pkg::qual_state_type             state_ff;
   ucpq_pkg::qual_state_type             state_in;
   ucpq_pkg::status_type                 status_ff;
   ucpq_pkg::status_type                 status_in;
   logic                                 rsp_valid_ff;
   logic [ucpq_pkg::LIMIT_WIDTH-1:0]     online_limit_ff;
   logic [ucpq_pkg::LIMIT_WIDTH-1:0]     absent_limit_ff;
   logic                                 req_fire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ucpq_pkg::RSP_DATA_WIDTH-3){1'b0}}, status_ff};

   ucpq_step u_step (
      .cur            (state_ff),
      .link_state     (req_tdata[1:0]),
      .supply_present (req_tdata[2]),
      .online_limit   (online_limit_ff),
      .absent_limit   (absent_limit_ff),
      .nxt            (state_in),
      .status         (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         online_limit_ff <= ucpq_pkg::ONLINE_SETTLE_RESET;
         absent_limit_ff <= ucpq_pkg::ABSENT_SETTLE_RESET;
      end else begin
         if (req_fire) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ucpq_pkg::CSR_ONLINE_SETTLE: online_limit_ff <= csr_data;
               ucpq_pkg::CSR_ABSENT_SETTLE: absent_limit_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
      end
   end

   // every accepted tick leaves a result in the rsp register
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (status_ff != 3'd6 && status_ff != 3'd7))
      else $error("illegal status code");

   // hold needs an earlier report to repeat
   a_hold_has_history: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (status_ff != ucpq_pkg::STATUS_HOLD ||
                    $past(state_ff.last_reported) != ucpq_pkg::LAST_NONE))
      else $error("hold with nothing reported before");

   // offline only comes from an online or power-on link
   a_offline_on_link: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (status_ff != ucpq_pkg::STATUS_OFFLINE ||
                    $past(req_tdata[1:0]) == ucpq_pkg::LINK_ONLINE ||
                    $past(req_tdata[1:0]) == ucpq_pkg::LINK_POWER_ON))
      else $error("offline reported on idle link");

   // state only moves with an accepted item
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(state_ff))
      else $error("debounce state changed without an item");

endmodule
